// File: hw/rtl/pcode_pkg.sv
// ----------------------------------------------------------------------------
// P-code stack machine package
// Shared types and constants for the p-code step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcode_pkg;

    localparam int STACK_DEPTH = 512;
    localparam int CODE_DEPTH  = 256;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(CODE_DEPTH);

    localparam logic [2:0] OP_LIT = 3'd0;
    localparam logic [2:0] OP_OPR = 3'd1;
    localparam logic [2:0] OP_LOD = 3'd2;
    localparam logic [2:0] OP_STO = 3'd3;
    localparam logic [2:0] OP_CAL = 3'd4;
    localparam logic [2:0] OP_INT = 3'd5;
    localparam logic [2:0] OP_JMP = 3'd6;
    localparam logic [2:0] OP_JPC = 3'd7;

    localparam logic [31:0] F_RET = 32'd0;
    localparam logic [31:0] F_NEG = 32'd1;
    localparam logic [31:0] F_ADD = 32'd2;
    localparam logic [31:0] F_SUB = 32'd3;
    localparam logic [31:0] F_MUL = 32'd4;
    localparam logic [31:0] F_DIV = 32'd5;
    localparam logic [31:0] F_ODD = 32'd6;
    localparam logic [31:0] F_EQ  = 32'd8;
    localparam logic [31:0] F_NE  = 32'd9;
    localparam logic [31:0] F_LT  = 32'd10;
    localparam logic [31:0] F_GE  = 32'd11;
    localparam logic [31:0] F_GT  = 32'd12;
    localparam logic [31:0] F_LE  = 32'd13;

    typedef enum logic [3:0] {
        T_CLR,
        T_IDLE,
        T_RD1,
        T_RD2,
        T_EXEC,
        T_DIVW,
        T_WR2,
        T_WR3,
        T_RDT,
        T_TOP,
        T_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

// File: hw/rtl/pcode_div.sv
// ----------------------------------------------------------------------------
// P-code divider
// Signed truncating 32-bit divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcode_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic signed [31:0]  i_den,
    output pcode_pkg::t_div_ctl o_ctl,
    output logic [31:0]         o_quo
);

    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_busy, n_busy;
    logic [32:0] w_sh;
    logic [32:0] w_dif;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_neg = r_neg; n_busy = r_busy;
        w_sh  = {r_rem[31:0], r_q[31]};
        w_dif = w_sh - {1'b0, r_den};
        if (i_start) begin
            n_q    = i_num[31] ? 32'(-i_num) : i_num;
            n_den  = i_den[31] ? 32'(-i_den) : i_den;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_neg  = i_num[31] ^ i_den[31];
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_dif[32]) begin
                n_rem = w_dif;
            end else begin
                n_rem = w_sh;
            end
            n_q   = {r_q[30:0], ~w_dif[32]};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt; r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_quo = r_neg ? 32'(-r_q) : r_q;

endmodule

// File: hw/rtl/pcode_stack_machine_step_core.sv
// ----------------------------------------------------------------------------
// P-code stack machine step core
// Executes one PL/0 p-code instruction per item on a 512-word stack.
// ----------------------------------------------------------------------------
// After reset the stack memory is cleared word by word, during which no
// item is taken. The single-port stack memory sets the pace. An instruction
// has a read of the top word, a second read, an execute and write cycle, a
// binary op writeback, a read of the new top word and the output cycle. An
// item taken in T_IDLE goes through T_RD1, T_RD2, T_EXEC, T_RDT and T_TOP,
// and its result is valid in T_OUT. CAL adds the states T_WR2 and T_WR3 for
// its frame writes; OPR divide by nonzero waits in T_DIVW for the bit-serial
// divider. One item is worked at a time, and the result is held until taken.
`timescale 1ns / 1ps

module pcode_stack_machine_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode[2:0], operand[34:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // next_pc[7:0], top_index[16:8],
                                        // base_index[25:17], top_value[57:26],
                                        // halted[58], error_code[59]
    output logic        m_axis_tuser    // unused flag, zero
);

    localparam int SW = pcode_pkg::SW;
    localparam int PW = pcode_pkg::PW;

    logic [31:0] r_mem [pcode_pkg::STACK_DEPTH];
    logic [SW-1:0] w_addr;
    logic [31:0] w_wdata;
    logic w_we;
    logic [31:0] r_rdata;

    pcode_pkg::t_state r_st, n_st;
    logic [SW-1:0] r_t, n_t, r_b, n_b;
    logic [PW-1:0] r_p, n_p;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_a, n_a;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic        r_err, n_err;
    logic [SW-1:0] r_clr, n_clr;
    logic        r_ov, n_ov;

    logic        w_start;
    pcode_pkg::t_div_ctl w_dctl;
    logic [31:0] w_quo;
    logic        w_bin;
    logic [31:0] w_res;

    // numerator s[t-1] is on the read port while the divide starts
    pcode_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(r_rdata), .i_den(r_y), .o_ctl(w_dctl), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    // binary op classes and their result
    always_comb begin
        w_bin = 1'b1;
        w_res = '0;
        case (r_a)
            pcode_pkg::F_ADD: w_res = r_x + r_y;
            pcode_pkg::F_SUB: w_res = r_x - r_y;
            pcode_pkg::F_MUL: w_res = r_x * r_y;
            pcode_pkg::F_DIV: w_res = (r_y == '0) ? '0 : w_quo;
            pcode_pkg::F_EQ:  w_res = {31'd0, r_x == r_y};
            pcode_pkg::F_NE:  w_res = {31'd0, r_x != r_y};
            pcode_pkg::F_LT:  w_res = {31'd0, $signed(r_x) <  $signed(r_y)};
            pcode_pkg::F_GE:  w_res = {31'd0, $signed(r_x) >= $signed(r_y)};
            pcode_pkg::F_GT:  w_res = {31'd0, $signed(r_x) >  $signed(r_y)};
            pcode_pkg::F_LE:  w_res = {31'd0, $signed(r_x) <= $signed(r_y)};
            default:          w_bin = 1'b0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            pcode_pkg::T_CLR: begin
                if (r_clr == SW'(pcode_pkg::STACK_DEPTH - 1)) n_st = pcode_pkg::T_IDLE;
            end
            pcode_pkg::T_IDLE: if (s_axis_tvalid) n_st = pcode_pkg::T_RD1;
            pcode_pkg::T_RD1:  n_st = pcode_pkg::T_RD2;
            pcode_pkg::T_RD2:  n_st = pcode_pkg::T_EXEC;
            pcode_pkg::T_EXEC: begin
                if (r_op == pcode_pkg::OP_OPR && r_a == pcode_pkg::F_DIV && r_y != '0) begin
                    n_st = pcode_pkg::T_DIVW;
                end else if (r_op == pcode_pkg::OP_CAL) begin
                    n_st = pcode_pkg::T_WR2;
                end else begin
                    n_st = pcode_pkg::T_RDT;
                end
            end
            pcode_pkg::T_DIVW: if (!w_dctl.busy && !w_dctl.start) n_st = pcode_pkg::T_RDT;
            pcode_pkg::T_WR2:  n_st = pcode_pkg::T_WR3;
            pcode_pkg::T_WR3:  n_st = pcode_pkg::T_RDT;
            pcode_pkg::T_RDT:  n_st = pcode_pkg::T_TOP;
            pcode_pkg::T_TOP:  n_st = pcode_pkg::T_OUT;
            pcode_pkg::T_OUT:  if (m_axis_tready) n_st = pcode_pkg::T_IDLE;
            default:           n_st = pcode_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        n_t = r_t; n_b = r_b; n_p = r_p; n_op = r_op; n_a = r_a;
        n_x = r_x; n_y = r_y; n_err = r_err; n_clr = r_clr;
        n_ov = r_ov;
        w_we = 1'b0; w_addr = r_t; w_wdata = '0; w_start = 1'b0;
        case (r_st)
            pcode_pkg::T_CLR: begin
                w_we = 1'b1; w_addr = r_clr; n_clr = r_clr + SW'(1);
            end
            pcode_pkg::T_IDLE: begin
                n_op = s_axis_tdata[2:0];
                n_a  = s_axis_tdata[34:3];
                n_err = 1'b0;
                if (s_axis_tvalid) n_p = r_p + PW'(1);
            end
            pcode_pkg::T_RD1: begin
                // top word, or return address for OPR 0
                if (r_op == pcode_pkg::OP_OPR && r_a == pcode_pkg::F_RET) begin
                    w_addr = r_b + SW'(2);
                end else begin
                    w_addr = r_t;
                end
            end
            pcode_pkg::T_RD2: begin
                n_y = r_rdata;
                if (r_op == pcode_pkg::OP_OPR && r_a == pcode_pkg::F_RET) begin
                    w_addr = r_b + SW'(1);
                end else if (r_op == pcode_pkg::OP_LOD) begin
                    w_addr = r_b + r_a[SW-1:0];
                end else begin
                    w_addr = r_t - SW'(1);
                end
            end
            pcode_pkg::T_EXEC: begin
                n_x = r_rdata;
                case (r_op)
                    pcode_pkg::OP_LIT: begin
                        n_t = r_t + SW'(1);
                        w_we = 1'b1; w_addr = r_t + SW'(1); w_wdata = r_a;
                    end
                    pcode_pkg::OP_LOD: begin
                        n_t = r_t + SW'(1);
                        w_we = 1'b1; w_addr = r_t + SW'(1); w_wdata = r_rdata;
                    end
                    pcode_pkg::OP_STO: begin
                        w_we = 1'b1; w_addr = r_b + r_a[SW-1:0]; w_wdata = r_y;
                        n_t = r_t - SW'(1);
                    end
                    pcode_pkg::OP_CAL: begin
                        w_we = 1'b1; w_addr = r_t + SW'(1);
                        w_wdata = 32'(r_b);
                        n_x = 32'(r_p);
                    end
                    pcode_pkg::OP_INT: n_t = r_t + r_a[SW-1:0];
                    pcode_pkg::OP_JMP: n_p = r_a[PW-1:0];
                    pcode_pkg::OP_JPC: begin
                        if (r_y == '0) n_p = r_a[PW-1:0];
                        n_t = r_t - SW'(1);
                    end
                    default: begin
                        if (r_a == pcode_pkg::F_RET) begin
                            // r_y holds s[b+2], rdata holds s[b+1]
                            n_t = r_b - SW'(1);
                            n_p = r_y[PW-1:0];
                            n_b = r_rdata[SW-1:0];
                        end else if (r_a == pcode_pkg::F_NEG) begin
                            w_we = 1'b1; w_wdata = 32'd0 - r_y;
                        end else if (r_a == pcode_pkg::F_ODD) begin
                            w_we = 1'b1;
                            w_wdata = r_y[0] ? (r_y[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
                        end else if (r_a == pcode_pkg::F_DIV) begin
                            w_start = (r_y != '0);
                        end
                        n_ov = 1'b1;
                    end
                endcase
            end
            pcode_pkg::T_WR2: begin
                w_we = 1'b1; w_addr = r_t + SW'(2); w_wdata = 32'(r_b);
            end
            pcode_pkg::T_WR3: begin
                w_we = 1'b1; w_addr = r_t + SW'(3); w_wdata = r_x;
                n_b = r_t + SW'(1);
                n_p = r_a[PW-1:0];
            end
            pcode_pkg::T_RDT: begin
                // binary op writeback, x=s[t-1] y=s[t]
                if (r_op == pcode_pkg::OP_OPR && r_ov && w_bin) begin
                    w_we = 1'b1; w_addr = r_t - SW'(1); w_wdata = w_res;
                    n_t = r_t - SW'(1);
                    n_err = (r_a == pcode_pkg::F_DIV) && (r_y == '0);
                end
                n_ov = 1'b0;
            end
            pcode_pkg::T_TOP: begin
                w_addr = r_t;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_a <= n_a; r_x <= n_x; r_y <= n_y;
        if (!i_rst_n) begin
            r_st <= pcode_pkg::T_CLR;
            r_t <= '0; r_b <= '0; r_p <= '0; r_err <= 1'b0;
            r_clr <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_t <= n_t; r_b <= n_b; r_p <= n_p; r_err <= n_err;
            r_clr <= n_clr; r_ov <= n_ov;
        end
    end

    // read port keeps s[t] while the result waits
    assign s_axis_tready = (r_st == pcode_pkg::T_IDLE);
    assign m_axis_tvalid = (r_st == pcode_pkg::T_OUT);
    assign m_axis_tuser  = 1'b0;
    assign m_axis_tdata  = {4'd0, r_err, (r_p == '0), r_rdata, r_b, r_t, r_p};

endmodule

// File: verif/pcode_stack_machine_step_core_tb.sv
// ----------------------------------------------------------------------------
// P-code stack machine step core testbench
// Sends p-code instructions with random gaps, forms the expected result of
// each one from a local copy of the machine state, and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcode_stack_machine_step_core_tb;

    typedef struct packed {
        logic        err;
        logic        halted;
        logic [31:0] top_word;
        logic [8:0]  base;
        logic [8:0]  top;
        logic [7:0]  pc;
    } t_step_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode[2:0], operand[34:3]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // next_pc, top_index, base_index, top_value,
                                 // halted, error_code
    logic        m_axis_tuser;   // unused flag

    logic [31:0] mach_stack [pcode_pkg::STACK_DEPTH];
    logic [8:0]  mach_top;
    logic [8:0]  mach_base;
    logic [7:0]  mach_pc;

    t_step_out   step_q [$];
    int          fail_cnt = 0;
    int          rx_wait = 0;
    bit          rx_quiet;

    pcode_stack_machine_step_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_step_out exec_instr(input logic [2:0] op, input logic [31:0] arg);
        logic [8:0]  lo;
        logic [8:0]  nt;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
        logic        bin;
        logic        err;
        t_step_out   o;
        err = 1'b0;
        mach_pc = mach_pc + 8'd1;
        case (op)
            pcode_pkg::OP_LIT: begin
                mach_top = mach_top + 9'd1;
                mach_stack[mach_top] = arg;
            end
            pcode_pkg::OP_OPR: begin
                if (arg == pcode_pkg::F_RET) begin
                    nt = mach_base - 9'd1;
                    mach_pc = mach_stack[9'(nt + 9'd3)][7:0];
                    mach_base = mach_stack[9'(nt + 9'd2)][8:0];
                    mach_top = nt;
                end else if (arg == pcode_pkg::F_NEG) begin
                    mach_stack[mach_top] = -mach_stack[mach_top];
                end else if (arg == pcode_pkg::F_ODD) begin
                    x = mach_stack[mach_top];
                    mach_stack[mach_top] = $signed(x) % 2;
                end else if (arg >= pcode_pkg::F_ADD && arg <= pcode_pkg::F_LE
                             && arg != 32'd7) begin
                    lo = mach_top - 9'd1;
                    x = mach_stack[lo];
                    y = mach_stack[mach_top];
                    bin = 1'b1;
                    r = '0;
                    case (arg)
                        pcode_pkg::F_ADD: r = x + y;
                        pcode_pkg::F_SUB: r = x - y;
                        pcode_pkg::F_MUL: r = x * y;
                        pcode_pkg::F_DIV: begin
                            if (y == 0) err = 1'b1;
                            else if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) r = x;
                            else r = $signed(x) / $signed(y);
                        end
                        pcode_pkg::F_EQ: r = 32'(x == y);
                        pcode_pkg::F_NE: r = 32'(x != y);
                        pcode_pkg::F_LT: r = 32'($signed(x) < $signed(y));
                        pcode_pkg::F_GE: r = 32'($signed(x) >= $signed(y));
                        pcode_pkg::F_GT: r = 32'($signed(x) > $signed(y));
                        pcode_pkg::F_LE: r = 32'($signed(x) <= $signed(y));
                        default: bin = 1'b0;
                    endcase
                    if (bin) begin
                        mach_stack[lo] = r;
                        mach_top = lo;
                    end
                end
            end
            pcode_pkg::OP_LOD: begin
                r = mach_stack[9'(mach_base + arg[8:0])];
                mach_top = mach_top + 9'd1;
                mach_stack[mach_top] = r;
            end
            pcode_pkg::OP_STO: begin
                mach_stack[9'(mach_base + arg[8:0])] = mach_stack[mach_top];
                mach_top = mach_top - 9'd1;
            end
            pcode_pkg::OP_CAL: begin
                mach_stack[9'(mach_top + 9'd1)] = 32'(mach_base);
                mach_stack[9'(mach_top + 9'd2)] = 32'(mach_base);
                mach_stack[9'(mach_top + 9'd3)] = 32'(mach_pc);
                mach_base = mach_top + 9'd1;
                mach_pc = arg[7:0];
            end
            pcode_pkg::OP_INT: mach_top = mach_top + arg[8:0];
            pcode_pkg::OP_JMP: mach_pc = arg[7:0];
            default: begin
                if (mach_stack[mach_top] == 0) mach_pc = arg[7:0];
                mach_top = mach_top - 9'd1;
            end
        endcase
        o.pc = mach_pc;
        o.top = mach_top;
        o.base = mach_base;
        o.top_word = mach_stack[mach_top];
        o.halted = (mach_pc == 8'd0);
        o.err = err;
        return o;
    endfunction

    // valid stays up after a take; it drops only before a gap and while draining
    task automatic send_instr(input logic [2:0] op, input logic [31:0] arg);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, arg, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_q.push_back(exec_instr(op, arg));
    endtask

    task automatic wait_drained;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (step_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic logic [31:0] rand_word;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_step_out got;
        t_step_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[59:0];
                if (step_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_cnt++;
                end else begin
                    want = step_q.pop_front();
                    if (got.pc !== want.pc)
                        $display("%0t: next_pc exp %h got %h", $time, want.pc, got.pc);
                    if (got.top !== want.top)
                        $display("%0t: top_index exp %h got %h", $time, want.top, got.top);
                    if (got.base !== want.base)
                        $display("%0t: base_index exp %h got %h", $time, want.base, got.base);
                    if (got.top_word !== want.top_word)
                        $display("%0t: top_value exp %h got %h", $time, want.top_word,
                                 got.top_word);
                    if (got.halted !== want.halted)
                        $display("%0t: halted exp %b got %b", $time, want.halted, got.halted);
                    if (got.err !== want.err)
                        $display("%0t: error_code exp %b got %b", $time, want.err, got.err);
                    if (got !== want) fail_cnt++;
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
            end else if (m_axis_tvalid && rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    task automatic test_basic_ops;
        int k;
        send_instr(pcode_pkg::OP_LIT, 32'h7FFF_FFFF);
        send_instr(pcode_pkg::OP_LIT, 32'h8000_0000);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_ADD);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_NEG);
        send_instr(pcode_pkg::OP_LIT, 32'h8000_0000);
        send_instr(pcode_pkg::OP_LIT, 32'hFFFF_FFFF);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_DIV);
        send_instr(pcode_pkg::OP_LIT, 32'd0);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_DIV);
        send_instr(pcode_pkg::OP_LIT, -32'd7);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_ODD);
        for (k = 3; k <= 13; k++) begin
            send_instr(pcode_pkg::OP_LIT, 32'($urandom_range(0, 3)));
            send_instr(pcode_pkg::OP_OPR, 32'(k));
        end
        send_instr(pcode_pkg::OP_OPR, 32'd7);
        send_instr(pcode_pkg::OP_OPR, 32'd14);
        send_instr(pcode_pkg::OP_OPR, 32'hFFFF_FFFF);
    endtask

    task automatic test_frames;
        send_instr(pcode_pkg::OP_INT, 32'd3);
        send_instr(pcode_pkg::OP_LOD, 32'hFFFF_FFFF);
        send_instr(pcode_pkg::OP_STO, 32'd600);
        send_instr(pcode_pkg::OP_CAL, 32'd300);
        send_instr(pcode_pkg::OP_INT, 32'h8000_0000);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_RET);
        send_instr(pcode_pkg::OP_JMP, 32'hFFFF_FF00);
        send_instr(pcode_pkg::OP_LIT, 32'd0);
        send_instr(pcode_pkg::OP_JPC, 32'd40);
        send_instr(pcode_pkg::OP_LIT, 32'd1);
        send_instr(pcode_pkg::OP_JPC, 32'd40);
        send_instr(pcode_pkg::OP_OPR, pcode_pkg::F_RET);
        send_instr(pcode_pkg::OP_INT, -32'd2);
    endtask

    task automatic test_random;
        int n;
        int k;
        logic [2:0] op;
        logic [31:0] arg;
        for (n = 0; n < 1820; n++) begin
            if (n == 900) begin
                wait_drained();
            end
            rx_quiet = (n % 300) < 60;
            k = $urandom_range(0, 99);
            op = 3'($urandom_range(0, 7));
            if (k < 10) arg = $urandom;
            else case (op)
                pcode_pkg::OP_LIT: arg = rand_word();
                pcode_pkg::OP_OPR: begin
                    arg = $urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 13);
                end
                pcode_pkg::OP_LOD, pcode_pkg::OP_STO: arg = $urandom_range(0, 8) - 3;
                pcode_pkg::OP_INT: arg = $urandom_range(0, 6) - 2;
                default: arg = $urandom_range(0, 255);
            endcase
            send_instr(op, arg);
        end
        rx_quiet = 1'b0;
    endtask

    initial begin
        int k;
        for (k = 0; k < pcode_pkg::STACK_DEPTH; k++) mach_stack[k] = '0;
        mach_top = '0;
        mach_base = '0;
        mach_pc = '0;
        rx_quiet = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_frames();
        test_random();
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && step_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pcode_pkg.sv
hw/rtl/pcode_div.sv
hw/rtl/pcode_stack_machine_step_core.sv
verif/pcode_stack_machine_step_core_tb.sv
